// File: sv/hln_pkg.sv
// Shared constants and the controller state type for the hand landmark normalizer.
// Depends on nothing; imported by the core.
package hln_pkg;

  localparam int MAX_JOINTS = 21;
  localparam int COORD_BITS = 16;
  localparam int FRAC_BITS  = COORD_BITS - 2;
  localparam int SQRT_EXTRA = 5;

  localparam int REL_W  = COORD_BITS + 1;            // relative coordinate, signed
  localparam int SQ_W   = 2 * REL_W;                 // sum of three squares
  localparam int RAD_W  = SQ_W + 2 * SQRT_EXTRA;     // square root radicand
  localparam int S_W    = RAD_W / 2;                 // distance with extra fraction bits
  localparam int SHIFT  = FRAC_BITS + SQRT_EXTRA;
  localparam int NUM_W  = COORD_BITS + SHIFT + 1;    // rounded dividend
  localparam int Q_W    = FRAC_BITS + 1;             // quotient magnitude
  localparam int MEM_W  = 3 * REL_W;
  localparam int IDX_W  = $clog2(MAX_JOINTS);
  localparam int CNT_W  = $clog2(MAX_JOINTS + 1);
  localparam int DCNT_W = $clog2(Q_W);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SQ,
    ST_ROOT_LD,
    ST_ROOT,
    ST_RD,
    ST_PREP,
    ST_DIV,
    ST_OUT
  } state_t;

endpackage

// File: sv/hand_landmark_normalizer_core.sv
// Hand landmark normalizer core: point store, squared distance tracking,
// square root and per-point division. Depends on hln_pkg.
//
// Usage:
//   Input: drive joint_x/y/z and set_end with start high; the point is taken
//   at a rising edge where start is high and busy is low. The first point of
//   a set is the origin; set_end marks the last point. Points past
//   MAX_JOINTS in one set are dropped, but their set_end still ends the set.
//   For each stored point, the accept cycle writes the relative point to the
//   store, then the ST_SQ steps square and accumulate the three coordinates
//   through one multiplier and update the running maximum.
//   Output: after the last point, a bit-serial square root runs, then each
//   stored point is read from the store and its three coordinates are
//   divided in parallel, one quotient bit a cycle; each result passes
//   through read, setup, the divide steps and output.
//   result_valid pulses for one cycle with norm_x/y/z and out_end; out_end
//   marks the last result of the set. The receiver cannot stall; busy
//   holds off new points until the final result is registered.
//   Reset (synchronous, active high) empties the set and returns to idle;
//   the store contents are not cleared, only entries written in the current
//   set are read.
module hand_landmark_normalizer_core
  import hln_pkg::*;
(
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         start,
  output logic                         busy,
  input  logic signed [COORD_BITS-1:0] joint_x,
  input  logic signed [COORD_BITS-1:0] joint_y,
  input  logic signed [COORD_BITS-1:0] joint_z,
  input  logic                         set_end,
  output logic                         result_valid,
  output logic signed [COORD_BITS-1:0] norm_x,
  output logic signed [COORD_BITS-1:0] norm_y,
  output logic signed [COORD_BITS-1:0] norm_z,
  output logic                         out_end
);

  state_t state, state_next;

  logic [MEM_W-1:0] store_mem [MAX_JOINTS];
  logic [MEM_W-1:0] rd_data;

  logic signed [COORD_BITS-1:0] origin [3];
  logic [CNT_W-1:0]             point_count;
  logic [SQ_W-1:0]              max_sq;

  logic signed [REL_W-1:0] rel_hold [3];
  logic                    end_flag;
  logic [1:0]              sq_idx;
  logic [SQ_W-1:0]         sq_prod;
  logic [SQ_W-1:0]         sq_acc;

  logic [RAD_W-1:0] root_v;
  logic [RAD_W-1:0] root_res;
  logic [RAD_W-1:0] root_bit;
  logic [S_W-1:0]   root_s;

  logic [IDX_W-1:0]  emit_idx;
  logic [DCNT_W-1:0] div_cnt;
  logic [S_W-1:0]    div_rem [3];
  logic [Q_W-1:0]    div_low [3];
  logic [Q_W-1:0]    div_q   [3];
  logic              lane_neg [3];
  logic [COORD_BITS-1:0] rel_lo [3];

  // control decode
  logic acc_fire, store_ok, mem_we, rd_en, emit_fire, emit_last;

  // datapath combinational
  logic signed [COORD_BITS-1:0] p_in [3];
  logic signed [REL_W-1:0]      rel_in [3];
  logic signed [REL_W-1:0]      sq_sel;
  logic signed [SQ_W-1:0]       sq_mul;
  logic [SQ_W-1:0]              sq_total;
  logic [RAD_W:0]               root_sum;
  logic                         root_ge;
  logic signed [REL_W-1:0]      rd_rel [3];
  logic [COORD_BITS-1:0]        rd_mag [3];
  logic [NUM_W-1:0]             lane_num [3];
  logic [S_W:0]                 div_t [3];
  logic                         div_ge [3];
  logic [COORD_BITS-1:0]        norm_val [3];

  assign store_ok  = point_count < CNT_W'(MAX_JOINTS);
  assign emit_last = (CNT_W'(emit_idx) + CNT_W'(1)) == point_count;

  assign p_in[0] = joint_x;
  assign p_in[1] = joint_y;
  assign p_in[2] = joint_z;

  // next state
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (start) begin
          if (store_ok) state_next = ST_SQ;
          else if (set_end) state_next = ST_ROOT_LD;
        end
      end
      ST_SQ: begin
        if (sq_idx == 2'd3) state_next = end_flag ? ST_ROOT_LD : ST_IDLE;
      end
      ST_ROOT_LD: state_next = ST_ROOT;
      ST_ROOT: begin
        if (root_bit[0]) state_next = ST_RD;
      end
      ST_RD:   state_next = ST_PREP;
      ST_PREP: state_next = ST_DIV;
      ST_DIV: begin
        if (div_cnt == DCNT_W'(Q_W - 1)) state_next = ST_OUT;
      end
      ST_OUT:  state_next = emit_last ? ST_IDLE : ST_RD;
      default: state_next = ST_IDLE;
    endcase
  end

  // control outputs
  always_comb begin
    busy      = 1'b1;
    acc_fire  = 1'b0;
    rd_en     = 1'b0;
    emit_fire = 1'b0;
    case (state)
      ST_IDLE: begin
        busy     = 1'b0;
        acc_fire = start;
      end
      ST_RD:   rd_en = 1'b1;
      ST_OUT:  emit_fire = 1'b1;
      default: busy = 1'b1;
    endcase
    mem_we = acc_fire && store_ok;
  end

  // datapath combinational
  always_comb begin
    for (int k = 0; k < 3; k++) begin
      rel_in[k] = (point_count == '0) ? '0
                : REL_W'(p_in[k]) - REL_W'(origin[k]);
    end

    case (sq_idx)
      2'd0:    sq_sel = rel_hold[0];
      2'd1:    sq_sel = rel_hold[1];
      2'd2:    sq_sel = rel_hold[2];
      default: sq_sel = '0;
    endcase
    sq_mul   = sq_sel * sq_sel;
    sq_total = sq_acc + sq_prod;

    root_sum = {1'b0, root_res} + {1'b0, root_bit};
    root_ge  = {1'b0, root_v} >= root_sum;

    for (int k = 0; k < 3; k++) begin
      rd_rel[k]   = $signed(rd_data[(2-k)*REL_W +: REL_W]);
      rd_mag[k]   = rd_rel[k][REL_W-1] ? COORD_BITS'(-rd_rel[k]) : COORD_BITS'(rd_rel[k]);
      lane_num[k] = NUM_W'({rd_mag[k], {SHIFT{1'b0}}}) + NUM_W'(root_s >> 1);
      div_t[k]    = {div_rem[k], div_low[k][Q_W-1]};
      div_ge[k]   = div_t[k] >= {1'b0, root_s};
      if (root_s == '0) norm_val[k] = rel_lo[k];
      else if (lane_neg[k]) norm_val[k] = -COORD_BITS'(div_q[k]);
      else norm_val[k] = COORD_BITS'(div_q[k]);
    end
  end

  // point store: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (mem_we) begin
      store_mem[point_count[IDX_W-1:0]] <= {rel_in[0], rel_in[1], rel_in[2]};
    end
    if (rd_en) begin
      rd_data <= store_mem[emit_idx];
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      point_count  <= '0;
      max_sq       <= '0;
      result_valid <= 1'b0;
      for (int k = 0; k < 3; k++) origin[k] <= '0;
    end else begin
      state        <= state_next;
      result_valid <= emit_fire;
      if (acc_fire && point_count == '0) begin
        for (int k = 0; k < 3; k++) origin[k] <= p_in[k];
      end
      if (mem_we) point_count <= point_count + CNT_W'(1);
      if (state == ST_SQ && sq_idx == 2'd3 && sq_total > max_sq) max_sq <= sq_total;
      // set delivered: empty the block for the next set
      if (emit_fire && emit_last) begin
        point_count <= '0;
        max_sq      <= '0;
        for (int k = 0; k < 3; k++) origin[k] <= '0;
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    if (acc_fire) begin
      for (int k = 0; k < 3; k++) rel_hold[k] <= rel_in[k];
      end_flag <= set_end;
      sq_idx   <= 2'd0;
    end

    if (state == ST_SQ) begin
      sq_idx  <= sq_idx + 2'd1;
      sq_prod <= SQ_W'(sq_mul);
      case (sq_idx)
        2'd0:    sq_acc <= '0;
        2'd1:    sq_acc <= sq_prod;
        default: sq_acc <= sq_total;
      endcase
    end

    if (state == ST_ROOT_LD) begin
      root_v   <= {max_sq, {(2*SQRT_EXTRA){1'b0}}};
      root_res <= '0;
      root_bit <= {2'b01, {(RAD_W-2){1'b0}}};
      emit_idx <= '0;
    end

    // one result bit per step
    if (state == ST_ROOT) begin
      if (root_ge) begin
        root_v   <= RAD_W'({1'b0, root_v} - root_sum);
        root_res <= (root_res >> 1) + root_bit;
      end else begin
        root_res <= root_res >> 1;
      end
      root_bit <= root_bit >> 2;
    end

    if (state == ST_RD) begin
      root_s <= root_res[S_W-1:0];
    end

    if (state == ST_PREP) begin
      div_cnt <= '0;
      for (int k = 0; k < 3; k++) begin
        div_rem[k]  <= S_W'(lane_num[k][NUM_W-1:Q_W]);
        div_low[k]  <= lane_num[k][Q_W-1:0];
        div_q[k]    <= '0;
        lane_neg[k] <= rd_rel[k][REL_W-1];
        rel_lo[k]   <= rd_rel[k][COORD_BITS-1:0];
      end
    end

    // restoring divide, three lanes share the divisor
    if (state == ST_DIV) begin
      div_cnt <= div_cnt + DCNT_W'(1);
      for (int k = 0; k < 3; k++) begin
        div_rem[k] <= div_ge[k] ? S_W'(div_t[k] - {1'b0, root_s}) : S_W'(div_t[k]);
        div_low[k] <= div_low[k] << 1;
        div_q[k]   <= {div_q[k][Q_W-2:0], div_ge[k]};
      end
    end

    if (emit_fire) begin
      norm_x   <= norm_val[0];
      norm_y   <= norm_val[1];
      norm_z   <= norm_val[2];
      out_end  <= emit_last;
      emit_idx <= emit_idx + IDX_W'(1);
    end
  end

`ifndef SYNTHESIS
  a_strobe_from_out: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> $past(state == ST_OUT))
    else $error("result strobe without output step");

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    point_count <= CNT_W'(MAX_JOINTS))
    else $error("point count beyond store depth");

  a_set_cleared: assert property (@(posedge clk) disable iff (rst)
    (emit_fire && emit_last) |=> (point_count == '0 && max_sq == '0))
    else $error("set not emptied after last beat");

  a_rem_below_divisor: assert property (@(posedge clk) disable iff (rst)
    (state == ST_DIV && root_s != '0) |-> (div_rem[0] < root_s && div_rem[1] < root_s
                                           && div_rem[2] < root_s))
    else $error("divider remainder out of range");

  a_origin_capture: assert property (@(posedge clk) disable iff (rst)
    (acc_fire && point_count == '0) |=> (origin[0] == $past(joint_x)
                                         && origin[1] == $past(joint_y)
                                         && origin[2] == $past(joint_z)))
    else $error("origin not taken from first point");
`endif

endmodule
